FILE: src/itp_pkg.sv
// Shared types, constants and helper functions of the infix to postfix converter.
// Used by every other file of the block but itp_ram; depends on nothing.

package itp_pkg;

  // Sizing of the operator stack and of the stored token identifier.
  localparam int STACK_DEPTH = 16;
  localparam int ID_BITS     = 16;

  // Fixed field widths of the channels.
  localparam int TOKEN_ID_W = 16;
  localparam int OP_W       = 4;
  localparam int PRIO_W     = 4;

  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W   = $clog2(STACK_DEPTH);
  localparam int ID_EXT_W = (ID_BITS > TOKEN_ID_W) ? ID_BITS : TOKEN_ID_W;

  typedef enum logic [OP_W-1:0] {
    TK_CONST  = 4'd0,
    TK_VAR    = 4'd1,
    TK_FUNC   = 4'd2,
    TK_COMMA  = 4'd3,
    TK_OPER   = 4'd4,
    TK_LPAREN = 4'd5,
    TK_RPAREN = 4'd6,
    TK_DELIM  = 4'd7,
    TK_END    = 4'd8
  } tok_kind_t;

  typedef enum logic [2:0] {
    RK_CONST = 3'd0,
    RK_VAR   = 3'd1,
    RK_FUNC  = 3'd2,
    RK_OPER  = 3'd3,
    RK_ERROR = 3'd4,
    RK_DONE  = 3'd5
  } res_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_COMMA    = 2'd1,
    ERR_PAREN    = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    EK_FUNC = 2'd0,
    EK_OPER = 2'd1,
    EK_LPAR = 2'd2
  } ent_kind_t;

  typedef enum logic [1:0] {
    SRC_TOKEN = 2'd0,
    SRC_TOP   = 2'd1,
    SRC_ERROR = 2'd2,
    SRC_DONE  = 2'd3
  } emit_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_EVAL,
    S_RWAIT,
    S_REVAL,
    S_FIN
  } state_t;

  typedef struct packed {
    ent_kind_t           kind;
    logic [ID_BITS-1:0]  id;
    logic [PRIO_W-1:0]   prio;
    logic                ra;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      emit;
    emit_src_t src;
    err_code_t err;
    logic      pop;
    logic      push;
    ent_kind_t push_kind;
    logic      clear_sp;
    logic      set_disc;
    logic      clr_disc;
    logic      finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    logic              ra;
    logic              disc;
    logic              empty;
    logic              full;
    ent_kind_t         top_kind;
    logic [PRIO_W-1:0] top_prio;
    logic              hold_v;
    logic              out_free;
  } dp_stat_t;

  // Bring an incoming identifier to the stored width.
  function automatic logic [ID_BITS-1:0] id_in(input logic [TOKEN_ID_W-1:0] x);
    logic [ID_EXT_W-1:0] t;
    t = ID_EXT_W'(x);
    return t[ID_BITS-1:0];
  endfunction

  // Bring a stored identifier to the result field width.
  function automatic logic [TOKEN_ID_W-1:0] id_out(input logic [ID_BITS-1:0] x);
    logic [ID_EXT_W-1:0] t;
    t = ID_EXT_W'(x);
    return t[TOKEN_ID_W-1:0];
  endfunction

endpackage

FILE: src/itp_ifs.sv
// Handshake interfaces of the token input channel and the result channel.
// Depends on itp_pkg for field widths.

interface itp_tok_if import itp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [TOKEN_ID_W-1:0] token_id;
  logic [PRIO_W-1:0]     priority_req;
  logic                  right_assoc;

  modport source (output valid, op, token_id, priority_req, right_assoc, input ready);
  modport sink   (input valid, op, token_id, priority_req, right_assoc, output ready);
endinterface

interface itp_res_if import itp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            out_kind;
  logic [TOKEN_ID_W-1:0] out_token_id;
  logic [1:0]            error_code;
  logic                  last;

  modport source (output valid, out_kind, out_token_id, error_code, last, input ready);
  modport sink   (input valid, out_kind, out_token_id, error_code, last, output ready);
endinterface

FILE: src/itp_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stands alone; used for the operator stack.

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/itp_dpath.sv
// Datapath of the converter: token register, stack pointer, operator stack RAM,
// hold register and output register. Depends on itp_pkg and itp_ram.

module itp_dpath import itp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [OP_W-1:0]       in_op,
  input  logic [TOKEN_ID_W-1:0] in_token_id,
  input  logic [PRIO_W-1:0]     in_priority_req,
  input  logic                  in_right_assoc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_kind,
  output logic [TOKEN_ID_W-1:0] out_token_id,
  output logic [1:0]            error_code,
  output logic                  out_last
);

  logic [OP_W-1:0]    tok_op_r;
  logic [ID_BITS-1:0] tok_id_r;
  logic [PRIO_W-1:0]  tok_prio_r;
  logic               tok_ra_r;

  logic [SP_W-1:0]    sp_r;
  logic               disc_r;

  logic               hold_v_r;
  res_kind_t          hold_kind_r;
  logic [ID_BITS-1:0] hold_id_r;
  err_code_t          hold_err_r;

  logic               out_valid_r;
  res_kind_t          out_kind_r;
  logic [ID_BITS-1:0] out_id_r;
  err_code_t          out_err_r;
  logic               out_last_r;

  logic [SP_W-1:0]    sp_m1;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t             top;
  entry_t             wr_ent;
  logic               push_we;

  res_kind_t          new_kind;
  logic [ID_BITS-1:0] new_id;
  err_code_t          new_err;
  logic               move_out;

  assign sp_m1   = sp_r - SP_W'(1);
  assign top     = entry_t'(rd_raw);
  assign push_we = cmd.push;

  always_comb begin
    wr_ent.kind = cmd.push_kind;
    wr_ent.id   = tok_id_r;
    wr_ent.prio = tok_prio_r;
    wr_ent.ra   = tok_ra_r;
  end

  // The read address always follows the top of the stack.
  itp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_we),
    .waddr (sp_r[ADDR_W-1:0]),
    .wdata (wr_ent),
    .raddr (sp_m1[ADDR_W-1:0]),
    .rdata (rd_raw)
  );

  always_comb begin
    unique case (cmd.src)
      SRC_TOKEN: begin
        new_kind = res_kind_t'(tok_op_r[2:0]);
        new_id   = tok_id_r;
        new_err  = ERR_NONE;
      end
      SRC_TOP: begin
        new_kind = (top.kind == EK_FUNC) ? RK_FUNC : RK_OPER;
        new_id   = top.id;
        new_err  = ERR_NONE;
      end
      SRC_ERROR: begin
        new_kind = RK_ERROR;
        new_id   = tok_id_r;
        new_err  = cmd.err;
      end
      default: begin
        new_kind = RK_DONE;
        new_id   = '0;
        new_err  = ERR_NONE;
      end
    endcase
  end

  assign move_out = hold_v_r && (cmd.emit || cmd.finish);

  // Token register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_op_r   <= in_op;
      tok_id_r   <= id_in(in_token_id);
      tok_prio_r <= in_priority_req;
      tok_ra_r   <= in_right_assoc;
    end
  end

  // Stack pointer and discard flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      disc_r <= 1'b0;
    end else begin
      if (cmd.clear_sp) begin
        sp_r <= '0;
      end else if (cmd.push) begin
        sp_r <= sp_r + SP_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_m1;
      end
      if (cmd.set_disc) begin
        disc_r <= 1'b1;
      end else if (cmd.clr_disc) begin
        disc_r <= 1'b0;
      end
    end
  end

  // A new word waits in the hold register until the next decision tells
  // whether it is the last one of the token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        hold_v_r <= 1'b1;
      end else if (cmd.finish) begin
        hold_v_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hold_kind_r <= new_kind;
      hold_id_r   <= new_id;
      hold_err_r  <= new_err;
    end
    if (move_out) begin
      out_kind_r <= hold_kind_r;
      out_id_r   <= hold_id_r;
      out_err_r  <= hold_err_r;
      out_last_r <= cmd.finish;
    end
  end

  always_comb begin
    stat.op       = tok_op_r;
    stat.prio     = tok_prio_r;
    stat.ra       = tok_ra_r;
    stat.disc     = disc_r;
    stat.empty    = (sp_r == '0);
    stat.full     = (sp_r == SP_W'(STACK_DEPTH));
    stat.top_kind = top.kind;
    stat.top_prio = top.prio;
    stat.hold_v   = hold_v_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_token_id = id_out(out_id_r);
  assign error_code   = out_err_r;
  assign out_last     = out_last_r;

endmodule

FILE: src/itp_ctrl.sv
// Controller state machine of the converter: decodes the held token against the
// stack top and sequences pops, pushes and result words. Depends on itp_pkg.

module itp_ctrl import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   stall;
  logic   op_pops;

  // An emit moves the held word out, so it waits for a free output register.
  assign stall = stat.hold_v && !stat.out_free;

  assign op_pops = stat.ra ? (stat.prio < stat.top_prio) : (stat.prio <= stat.top_prio);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (stat.disc) begin
          if (stat.op == TK_END) begin
            cmd.clr_disc = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          unique case (tok_kind_t'(stat.op))
            TK_CONST, TK_VAR: begin
              if (!stall) begin
                cmd.emit  = 1'b1;
                cmd.src   = SRC_TOKEN;
                state_nxt = S_FIN;
              end
            end

            TK_FUNC, TK_LPAREN, TK_OPER: begin
              if (stat.op == TK_OPER && !stat.empty && stat.top_kind == EK_OPER
                  && op_pops) begin
                if (!stall) begin
                  cmd.emit  = 1'b1;
                  cmd.src   = SRC_TOP;
                  cmd.pop   = 1'b1;
                  state_nxt = S_WAIT;
                end
              end else if (stat.full) begin
                if (!stall) begin
                  cmd.emit     = 1'b1;
                  cmd.src      = SRC_ERROR;
                  cmd.err      = ERR_OVERFLOW;
                  cmd.clear_sp = 1'b1;
                  cmd.set_disc = 1'b1;
                  state_nxt    = S_FIN;
                end
              end else begin
                cmd.push = 1'b1;
                if (stat.op == TK_FUNC) begin
                  cmd.push_kind = EK_FUNC;
                end else if (stat.op == TK_LPAREN) begin
                  cmd.push_kind = EK_LPAR;
                end else begin
                  cmd.push_kind = EK_OPER;
                end
                state_nxt = S_FIN;
              end
            end

            TK_COMMA, TK_RPAREN: begin
              if (!stat.empty && stat.top_kind != EK_LPAR) begin
                if (!stall) begin
                  cmd.emit  = 1'b1;
                  cmd.src   = SRC_TOP;
                  cmd.pop   = 1'b1;
                  state_nxt = S_WAIT;
                end
              end else if (stat.empty) begin
                if (!stall) begin
                  cmd.emit     = 1'b1;
                  cmd.src      = SRC_ERROR;
                  cmd.err      = (stat.op == TK_COMMA) ? ERR_COMMA : ERR_PAREN;
                  cmd.clear_sp = 1'b1;
                  cmd.set_disc = 1'b1;
                  state_nxt    = S_FIN;
                end
              end else if (stat.op == TK_RPAREN) begin
                // Drop the matching left parenthesis, then look for a function.
                cmd.pop   = 1'b1;
                state_nxt = S_RWAIT;
              end else begin
                state_nxt = S_FIN;
              end
            end

            TK_END: begin
              if (!stall) begin
                cmd.emit = 1'b1;
                if (!stat.empty && stat.top_kind == EK_OPER) begin
                  cmd.src   = SRC_TOP;
                  cmd.pop   = 1'b1;
                  state_nxt = S_WAIT;
                end else if (!stat.empty) begin
                  cmd.src      = SRC_ERROR;
                  cmd.err      = ERR_PAREN;
                  cmd.clear_sp = 1'b1;
                  state_nxt    = S_FIN;
                end else begin
                  cmd.src   = SRC_DONE;
                  state_nxt = S_FIN;
                end
              end
            end

            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_RWAIT: begin
        state_nxt = S_REVAL;
      end

      S_REVAL: begin
        if (!stat.empty && stat.top_kind == EK_FUNC) begin
          if (!stall) begin
            cmd.emit  = 1'b1;
            cmd.src   = SRC_TOP;
            cmd.pop   = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!stat.hold_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter (shunting-yard scheme).
// Depends on itp_pkg, itp_ifs, itp_ctrl and itp_dpath.
//
//   Channel  Dir  Handshake      Word
//   in_tok   in   valid/ready    op, token_id, priority_req, right_assoc
//   out_res  out  valid/ready    out_kind, out_token_id, error_code, last
//
// A token that pushes or emits at once passes S_WAIT, S_EVAL and S_FIN before the
// block is ready again. Every popped entry adds a pass through S_WAIT and S_EVAL,
// as the stack RAM has a registered read and the new top is fetched before the
// next compare; a right parenthesis adds S_RWAIT and S_REVAL, even over a function.
// Synchronous reset (rst_n low) clears the stack, discard mode, held and output words and FSM.
// A stalled result channel holds the controller wherever another word must leave.

module infix_to_postfix_converter import itp_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  itp_tok_if.sink   in_tok,
  itp_res_if.source out_res
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // The controller only takes a token when the previous one is fully handled;
  // the output register lets the last word drain while the next token arrives.
  assign in_tok.ready = in_ready;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tok.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds each result word back by one decision so that the
  // last flag can be set on the final word of a token.
  itp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_tok.op),
    .in_token_id     (in_tok.token_id),
    .in_priority_req (in_tok.priority_req),
    .in_right_assoc  (in_tok.right_assoc),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_kind        (out_res.out_kind),
    .out_token_id    (out_res.out_token_id),
    .error_code      (out_res.error_code),
    .out_last        (out_res.last)
  );

endmodule
